/* sv/dss_pkg.sv */
// Package for the delimiter stream splitter: word types, configuration
// register layout and register index codes.
// No dependencies; every other file of the block imports it.
`default_nettype none

package dss_pkg;

  // Configuration port geometry: two registers, one of them 64 bits wide,
  // so registers sit at 8-byte strides and the address bit 3 picks one.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 64;

  // Register index codes, taken from the address bit above the stride.
  localparam logic REG_DELIM_LENGTH = 1'b0;
  localparam logic REG_DELIM_BYTES  = 1'b1;

  // One input word: a stream byte and its end-of-stream flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       segment_end;
    logic       no_delimiter_error;
    logic       last_of_run;
  } out_item_t;

  // Configuration register contents as seen by the datapath.
  typedef struct packed {
    logic [3:0]  delimiter_length;
    logic [63:0] delimiter_bytes;
  } cfg_regs_t;

endpackage

`default_nettype wire

/* sv/dss_cfg_regs.sv */
// APB-style configuration registers of the delimiter stream splitter.
// Depends on dss_pkg for the register layout and index codes.
`default_nettype none

module dss_cfg_regs
  import dss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_regs_t         cfg_o
);

  logic [3:0]  delim_len_r;
  logic [63:0] delim_bytes_r;
  logic        wr_en;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CFG_AW-1];

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_len_r   <= 4'd1;
      delim_bytes_r <= 64'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DELIM_LENGTH: delim_len_r   <= pwdata[3:0];
        REG_DELIM_BYTES:  delim_bytes_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back the raw register values.
  always_comb begin
    unique case (reg_idx)
      REG_DELIM_LENGTH: prdata = {60'd0, delim_len_r};
      REG_DELIM_BYTES:  prdata = delim_bytes_r;
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.delimiter_length = delim_len_r;
  assign cfg_o.delimiter_bytes  = delim_bytes_r;

endmodule

`default_nettype wire

/* sv/dss_split_logic.sv */
// Single-pass split logic: appends one byte to the held window, finds the
// first window offset that is a full delimiter match or a proper prefix,
// and builds the run of result words. Depends on dss_pkg.
`default_nettype none

module dss_split_logic
  import dss_pkg::*;
#(
  parameter  int MAX_DELIM = 8,
  localparam int FW        = $clog2(MAX_DELIM + 1)
) (
  input  logic [MAX_DELIM-1:0][7:0] win_i,
  input  logic [FW-1:0]             fill_i,
  input  logic                      seen_i,
  input  in_item_t                  item_i,
  input  cfg_regs_t                 cfg_i,
  output logic [MAX_DELIM-1:0][7:0] win_o,
  output logic [FW-1:0]             fill_o,
  output logic                      seen_o,
  output out_item_t [MAX_DELIM-1:0] run_o,
  output logic [FW-1:0]             run_cnt_o
);

  logic [MAX_DELIM-1:0][7:0]       nw;
  logic [MAX_DELIM-1:0][7:0]       dl;
  logic [MAX_DELIM:0][MAX_DELIM-1:0] eq;
  logic [MAX_DELIM:0]              full_v;
  logic [MAX_DELIM:0]              stop_v;
  logic [3:0]                      len_c;
  logic [FW-1:0]                   len;
  logic [FW-1:0]                   nf;
  logic [FW-1:0]                   s;
  logic [FW-1:0]                   kstar;
  logic [FW-1:0]                   dcount;
  logic [FW-1:0]                   nres;
  logic                            hit_full;
  logic                            ok_f;
  logic                            ok_p;
  logic                            fin;

  assign fin = item_i.final_byte;

  // Effective delimiter length: zero acts as one, clamp to the window depth.
  always_comb begin
    len_c = cfg_i.delimiter_length;
    if (len_c == 4'd0) begin
      len_c = 4'd1;
    end else if (len_c > 4'(MAX_DELIM)) begin
      len_c = 4'(MAX_DELIM);
    end
    len = len_c[FW-1:0];
  end

  // Window with the new byte placed after the held ones.
  always_comb begin
    nf = fill_i + FW'(1);
    for (int j = 0; j < MAX_DELIM; j++) begin
      dl[j] = cfg_i.delimiter_bytes[8*j +: 8];
      nw[j] = win_i[j];
      if (FW'(j) == fill_i) begin
        nw[j] = item_i.data_byte;
      end
    end
  end

  // Byte compares of every window offset against every delimiter position.
  always_comb begin
    for (int k = 0; k <= MAX_DELIM; k++) begin
      for (int i = 0; i < MAX_DELIM; i++) begin
        eq[k][i] = 1'b0;
        if (k + i < MAX_DELIM) begin
          eq[k][i] = (nw[k+i] == dl[i]);
        end
      end
    end
  end

  // Stop condition at each offset: the rest of the window is a full match
  // or still a proper prefix of the delimiter.
  always_comb begin
    s    = '0;
    ok_f = 1'b1;
    ok_p = 1'b1;
    for (int k = 0; k <= MAX_DELIM; k++) begin
      s    = nf - FW'(k);
      ok_f = 1'b1;
      ok_p = 1'b1;
      for (int i = 0; i < MAX_DELIM; i++) begin
        if ((FW'(i) < len) && !eq[k][i]) ok_f = 1'b0;
        if ((FW'(i) < s) && !eq[k][i]) ok_p = 1'b0;
      end
      full_v[k] = (FW'(k) <= nf) && (s == len) && ok_f;
      stop_v[k] = full_v[k] || ((FW'(k) <= nf) && (s < len) && ok_p);
    end
  end

  // The smallest stopping offset is the number of bytes released as data.
  always_comb begin
    kstar    = FW'(MAX_DELIM);
    hit_full = 1'b0;
    for (int k = MAX_DELIM; k >= 0; k--) begin
      if (stop_v[k]) begin
        kstar    = FW'(k);
        hit_full = full_v[k];
      end
    end
  end

  // Next window: drop the released head bytes.
  always_comb begin
    for (int j = 0; j < MAX_DELIM; j++) begin
      win_o[j] = '0;
      for (int m = 0; m <= MAX_DELIM; m++) begin
        if ((FW'(m) == kstar) && (j + m < MAX_DELIM)) begin
          win_o[j] = nw[j+m];
        end
      end
    end
    if (fin || hit_full) begin
      fill_o = '0;
    end else begin
      fill_o = nf - kstar;
    end
    seen_o = fin ? 1'b0 : (seen_i | hit_full);
  end

  // Result run: released data bytes, then either the segment-end word of a
  // match or, on the final byte, the flushed rest of the window.
  always_comb begin
    dcount    = (fin && !hit_full) ? nf : kstar;
    nres      = dcount + FW'(hit_full);
    run_cnt_o = nres;
    for (int j = 0; j < MAX_DELIM; j++) begin
      run_o[j] = '0;
      if (FW'(j) < dcount) begin
        run_o[j].out_byte = nw[j];
        run_o[j].has_data = 1'b1;
      end else if ((FW'(j) == dcount) && hit_full) begin
        run_o[j].segment_end = 1'b1;
      end
      if ((nres != '0) && (FW'(j) == nres - FW'(1))) begin
        run_o[j].last_of_run = 1'b1;
        if (fin && !hit_full) begin
          run_o[j].segment_end = 1'b1;
        end
        if (fin && !(seen_i || hit_full)) begin
          run_o[j].no_delimiter_error = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/dss_result_queue.sv */
// Result register of the splitter: holds the run of result words caused by
// one input word and hands them out one per output handshake.
// Depends on dss_pkg for the result word type.
`default_nettype none

module dss_result_queue
  import dss_pkg::*;
#(
  parameter  int MAX_DELIM = 8,
  localparam int FW        = $clog2(MAX_DELIM + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  out_item_t [MAX_DELIM-1:0] load_run,
  input  logic [FW-1:0]             load_cnt,
  output logic                      free,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data
);

  out_item_t [MAX_DELIM-1:0] run_r;
  logic [FW-1:0]             cnt_r;
  logic                      pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = run_r[0];
  assign pop       = out_valid & out_ready;
  // A new run may enter once the last word of the current one leaves.
  assign free      = (cnt_r == '0) || ((cnt_r == FW'(1)) && out_ready);

  // Word count of the run still waiting.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= load_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - FW'(1);
    end
  end

  // Run words shift toward the head as they are taken.
  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= load_run;
    end else if (pop) begin
      for (int j = 0; j < MAX_DELIM - 1; j++) begin
        run_r[j] <= run_r[j+1];
      end
    end
  end

endmodule

`default_nettype wire

/* sv/delimiter_stream_splitter_unit.sv */
// Top level of the delimiter stream splitter: input register, window state,
// split logic, result register and configuration registers.
// Depends on dss_pkg, dss_cfg_regs, dss_split_logic and dss_result_queue.
//
//   channel  direction  handshake           word
//   in_      input      in_valid/in_ready   in_item_t (data_byte, final_byte)
//   out_     output     out_valid/out_ready out_item_t (five result fields)
//   cfg      input      psel/penable/pready APB write/read, 64-bit registers
//
// A byte is accepted every cycle while results keep pace; the path from input
// to the first result passes the input register, then the result register.
// An input byte that causes m results holds the result register until all m
// have left, one per output handshake; a byte that only joins the window needs
// no result slot. Output stalls reach the input through the result register.
// Reset is synchronous and active low and needs no clearing pass.
`default_nettype none

module delimiter_stream_splitter_unit
  import dss_pkg::*;
#(
  parameter int MAX_DELIM = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int FW = $clog2(MAX_DELIM + 1);

  cfg_regs_t                 cfg;
  in_item_t                  inq_r;
  logic                      inq_v_r;
  logic [MAX_DELIM-1:0][7:0] win_r;
  logic [MAX_DELIM-1:0][7:0] win_nxt;
  logic [FW-1:0]             fill_r;
  logic [FW-1:0]             fill_nxt;
  logic                      seen_r;
  logic                      seen_nxt;
  out_item_t [MAX_DELIM-1:0] run;
  logic [FW-1:0]             run_cnt;
  logic                      q_free;
  logic                      adv;
  logic                      load;

  dss_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dss_split_logic #(.MAX_DELIM(MAX_DELIM)) u_split (
    .win_i     (win_r),
    .fill_i    (fill_r),
    .seen_i    (seen_r),
    .item_i    (inq_r),
    .cfg_i     (cfg),
    .win_o     (win_nxt),
    .fill_o    (fill_nxt),
    .seen_o    (seen_nxt),
    .run_o     (run),
    .run_cnt_o (run_cnt)
  );

  dss_result_queue #(.MAX_DELIM(MAX_DELIM)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_run  (run),
    .load_cnt  (run_cnt),
    .free      (q_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The held word advances when its results have a place to go.
  assign adv      = inq_v_r && ((run_cnt == '0) || q_free);
  assign load     = adv && (run_cnt != '0);
  assign in_ready = !inq_v_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_v_r <= 1'b0;
    end else if (in_ready) begin
      inq_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inq_r <= in_data;
    end
  end

  // Window state, updated once per processed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      seen_r <= 1'b0;
    end else if (adv) begin
      fill_r <= fill_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win_r <= win_nxt;
    end
  end

  // The window holds fewer bytes than its depth between words.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < FW'(MAX_DELIM))
    else $error("window fill reached the window depth");

  // A run is only loaded into a result register that is free.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> q_free)
    else $error("result run loaded over pending results");

  // A result without data is always a segment end.
  a_nodata_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_data) |-> out_data.segment_end)
    else $error("empty result that does not close a segment");

  // The missing-delimiter flag only rides on the last result of a word.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.no_delimiter_error) |-> out_data.last_of_run)
    else $error("error flag on a result that is not last of its run");

endmodule

`default_nettype wire

/* dv/dss_stream_checker.sv */
`timescale 1ns / 100ps
// Checker for the delimiter stream splitter: watches the input, result and
// register ports, predicts every result word and compares it field by field.
// Depends on dss_pkg for the word types and register index codes.

module dss_stream_checker
  import dss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int unsigned       err_count,
  output int unsigned       pending_count
);

  localparam int unsigned WIN_DEPTH = 8;

  // Shadow copy of the registers and of the match window.
  logic [3:0]  len_reg;
  logic [63:0] delim_reg;
  logic [7:0]  win [WIN_DEPTH];
  int unsigned fill;
  bit          seg_open;
  bit          seen_delim;

  // Result words predicted but not yet seen, oldest first.
  out_item_t   segment_q[$];

  function automatic void clear_window();
    for (int i = 0; i < WIN_DEPTH; i++) win[i] = '0;
    fill = 0;
  endfunction

  // True when the first n held bytes equal the first n delimiter bytes.
  function automatic bit window_is_prefix(int unsigned n);
    for (int i = 0; i < n && i < WIN_DEPTH; i++)
      if (win[i] != delim_reg[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // Removes the oldest held byte and returns it as a data word.
  function automatic out_item_t emit_oldest();
    out_item_t r;
    r = '0;
    r.out_byte = win[0];
    r.has_data = 1'b1;
    for (int i = 1; i < WIN_DEPTH; i++) win[i-1] = win[i];
    win[WIN_DEPTH-1] = '0;
    if (fill > 0) fill--;
    seg_open = 1'b1;
    return r;
  endfunction

  // Works out the result words caused by one accepted input word.
  task automatic split_word(input in_item_t w);
    int unsigned span;
    out_item_t   run[$];
    out_item_t   r;
    span = (len_reg == 0) ? 1 : ((len_reg > WIN_DEPTH) ? WIN_DEPTH : len_reg);
    if (fill >= WIN_DEPTH) run.push_back(emit_oldest());
    win[fill % WIN_DEPTH] = w.data_byte;
    fill++;

    // Emit head bytes until the window is a full match or a proper prefix.
    while (fill > 0 && run.size() < WIN_DEPTH) begin
      if (fill == span && window_is_prefix(span)) begin
        r = '0;
        r.segment_end = 1'b1;
        run.push_back(r);
        clear_window();
        seg_open = 1'b0;
        seen_delim = 1'b1;
        break;
      end
      if (fill < span && window_is_prefix(fill)) break;
      run.push_back(emit_oldest());
    end

    // The final byte flushes the window and closes the stream.
    if (w.final_byte) begin
      while (fill > 0 && run.size() < WIN_DEPTH) run.push_back(emit_oldest());
      if (run.size() > 0 && seg_open) run[run.size()-1].segment_end = 1'b1;
      if (run.size() > 0 && !seen_delim) run[run.size()-1].no_delimiter_error = 1'b1;
      clear_window();
      seg_open = 1'b0;
      seen_delim = 1'b0;
    end

    if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) segment_q.push_back(run[i]);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  // Results are compared before the input word of the same edge is
  // predicted, so a word can never be matched against its own prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      len_reg = 4'd1;
      delim_reg = '0;
      clear_window();
      seg_open = 1'b0;
      seen_delim = 1'b0;
      segment_q.delete();
      err_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (segment_q.size() == 0) begin
          $error("result word 0x%0h arrived with nothing expected", out_data);
          err_count++;
        end else begin
          want = segment_q.pop_front();
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("has_data", want.has_data, out_data.has_data);
          check_field("segment_end", want.segment_end, out_data.segment_end);
          check_field("no_delimiter_error", want.no_delimiter_error,
                      out_data.no_delimiter_error);
          check_field("last_of_run", want.last_of_run, out_data.last_of_run);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[CFG_AW-1] == REG_DELIM_BYTES) delim_reg = pwdata;
        else len_reg = pwdata[3:0];
      end
      if (in_valid && in_ready) split_word(in_data);
    end
    pending_count <= segment_q.size();
  end

endmodule

/* dv/tb_delimiter_stream_splitter_unit.sv */
`timescale 1ns / 100ps
// Testbench top for the delimiter stream splitter: clock, reset, register
// writes, byte streams and result back-pressure, plus the final verdict.
// Depends on dss_pkg, the block's RTL and dss_stream_checker.

module tb_delimiter_stream_splitter_unit;
  import dss_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_WORDS = 42;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  int unsigned       err_count;
  int unsigned       pending_count;

  // Stimulus controls; sink_burst and hold_requests are shared with the receiver process.
  bit                src_burst;
  bit                sink_burst;
  int unsigned       hold_requests;
  logic [7:0]        stream_q[$];

  delimiter_stream_splitter_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  dss_stream_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .err_count    (err_count),
    .pending_count(pending_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned eff_span(input logic [3:0] len);
    if (len == 0) return 1;
    if (len > 8) return 8;
    return int'(len);
  endfunction

  // Receiver: random stalls, plus a long hold whenever one is requested.
  initial begin
    int unsigned stall_left;
    int unsigned holds_done;
    out_ready = 1'b0;
    stall_left = 0;
    holds_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        out_ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (!sink_burst && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // Offers one word and returns at a falling edge once it is taken and any
  // gap that follows has passed, with valid lowered only during that gap.
  task automatic send_word(input logic [7:0] b, input logic fin);
    int unsigned g;
    in_data.data_byte = b;
    in_data.final_byte = fin;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    g = src_burst ? 0 : gap_len();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Sends stream_q as one stream, the last byte marked final.
  task automatic send_stream();
    foreach (stream_q[i]) send_word(stream_q[i], i == stream_q.size() - 1);
  endtask

  // Waits until every predicted word has come out and the pipeline drained.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_DW-1:0] val);
    wait_idle();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, {(CFG_AW-1){1'b0}}};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_delim(input logic [3:0] len, input logic [63:0] bytes);
    cfg_write(REG_DELIM_LENGTH, {{(CFG_DW-4){1'b0}}, len});
    cfg_write(REG_DELIM_BYTES, bytes);
  endtask

  // Random stream built from whole delimiters, partial delimiters, bytes of
  // the delimiter's small alphabet and arbitrary noise bytes.
  task automatic build_stream(input int unsigned span, input logic [63:0] delim,
                              input logic [7:0] alpha0, input logic [7:0] alpha1);
    int unsigned target;
    int unsigned pick;
    int unsigned cut;
    stream_q.delete();
    target = $urandom_range(1, 24);
    while (stream_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        for (int i = 0; i < span; i++) stream_q.push_back(delim[8*i +: 8]);
      end else if (pick < 55) begin
        cut = $urandom_range(1, span);
        for (int i = 0; i < cut; i++) stream_q.push_back(delim[8*i +: 8]);
      end else if (pick < 85) begin
        stream_q.push_back($urandom_range(0, 1) ? alpha0 : alpha1);
      end else begin
        stream_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    logic [3:0]  len;
    logic [63:0] delim;
    logic [7:0]  alpha0;
    logic [7:0]  alpha1;
    int unsigned sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    src_burst = 1'b0;
    sink_burst = 1'b0;
    hold_requests = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Single zero byte delimiter, zero byte then an all-ones final byte.
    set_delim(4'd1, 64'h0);
    stream_q = '{8'h00, 8'hFF};
    send_stream();

    // Length zero behaves as one; back-to-back delimiters give empty segments.
    set_delim(4'd0, 64'h2C);
    stream_q = '{8'h61, 8'h2C, 8'h2C, 8'h62};
    send_stream();

    // Overlapping partial match must be retried after dropping its head.
    set_delim(4'd3, 64'h626161);
    stream_q = '{8'h61, 8'h61, 8'h61, 8'h62};
    send_stream();

    // Stream shorter than the delimiter never matches.
    stream_q = '{8'h61};
    send_stream();

    // Delimiter changed while bytes are held in the window.
    send_word(8'h61, 1'b0);
    send_word(8'h61, 1'b0);
    set_delim(4'd2, 64'h6261);
    send_word(8'h62, 1'b0);
    send_word(8'h78, 1'b1);

    // Length above the maximum clamps to eight; the flush gives eight words.
    set_delim(4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    stream_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_stream();

    // Random phases, each with its own delimiter setting.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: len = 4'd1;
        1: len = 4'd2;
        2: len = 4'd3;
        3: len = 4'd8;
        4: len = 4'd0;
        5: len = 4'd15;
        default: len = 4'($urandom_range(0, 15));
      endcase
      alpha0 = 8'($urandom_range(0, 255));
      alpha1 = 8'($urandom_range(0, 255));
      for (int i = 0; i < 8; i++) delim[8*i +: 8] = $urandom_range(0, 1) ? alpha0 : alpha1;
      set_delim(len, delim);
      src_burst = ($urandom_range(0, 3) == 0);
      sink_burst = ($urandom_range(0, 3) == 0);

      // One phase runs with the receiver held off while bytes keep coming.
      if (p == 1) begin
        src_burst = 1'b1;
        hold_requests++;
      end

      sent = 0;
      while (sent < PHASE_WORDS) begin
        build_stream(eff_span(len), delim, alpha0, alpha1);
        send_stream();
        sent += stream_q.size();
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (err_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
